// File: hdl/pca_pkg.sv
// Shared types, constants and helpers for the pixel color adjust pipeline.
package pca_pkg;

  // Field and register widths
  localparam int CH_W      = 8;
  localparam int FACTOR_W  = 16;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Internal datapath widths
  localparam int LUMA_W  = 24;  // 255 * 65536 fits
  localparam int SEPIA_W = 19;  // 255 * 1383 fits
  localparam int DIFF_W  = 25;  // c*2^16 - luma, signed
  localparam int PROD_W  = DIFF_W + FACTOR_W;
  localparam int SUM_W   = PROD_W + 1;

  // Luma weights, Q0.16
  localparam logic [15:0] LUMA_KR = 16'd19595;
  localparam logic [15:0] LUMA_KG = 16'd38470;
  localparam logic [15:0] LUMA_KB = 16'd7471;

  // Sepia weights, Q0.10, indexed [row][col]; row is the output channel
  localparam logic [2:0][2:0][9:0] SEPIA_K = {
    {10'd134, 10'd547, 10'd279},
    {10'd172, 10'd702, 10'd357},
    {10'd194, 10'd787, 10'd402}
  };
  localparam int SEPIA_SHIFT = 10;

  localparam int CONTRAST_MID  = 128;
  localparam int CONTRAST_BIAS = 32768;  // 128 << 8, folds the +128 into the floor
  localparam int CH_MAX        = 255;

  // Operation select
  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY     = 3'd0,
    MODE_SEPIA    = 3'd1,
    MODE_INVERT   = 3'd2,
    MODE_BRIGHT   = 3'd3,
    MODE_CONTRAST = 3'd4,
    MODE_SAT      = 3'd5
  } mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_FACTOR = 2'd1;

  localparam logic [MODE_W-1:0]   MODE_RESET   = 3'd0;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;

  typedef logic [CH_W-1:0] chan_t;

  // Sideband that rides along with every pixel
  typedef struct packed {
    chan_t alpha;
    logic  last;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [2:0][CH_W-1:0] rgb;
  } pix_t;

  typedef struct packed {
    side_t                 side;
    logic [2:0][CH_W-1:0]    rgb;
    logic [LUMA_W-1:0]       luma;
    logic [2:0][SEPIA_W-1:0] sepia;
  } s1_t;

  typedef struct packed {
    side_t                 side;
    logic [2:0][CH_W-1:0]    rgb;
    logic [LUMA_W-1:0]       luma;
    logic [2:0][SEPIA_W-1:0] sepia;
    logic [2:0][DIFF_W-1:0]  diff;
  } s2_t;

  typedef struct packed {
    side_t                 side;
    logic [2:0][CH_W-1:0]    rgb;
    logic [LUMA_W-1:0]       luma;
    logic [2:0][SEPIA_W-1:0] sepia;
    logic [2:0][PROD_W-1:0]  prod;
  } s3_t;

  // Clamp a signed value to 0..255
  function automatic chan_t clamp8(input logic signed [SUM_W-1:0] v);
    chan_t res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SUM_W'(CH_MAX))) begin
      res = CH_W'(CH_MAX);
    end else begin
      res = v[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/pca_luma.sv
// Stage 1: luma and sepia weighted sums.
module pca_luma import pca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  pix_t up_pix,
  output logic dn_valid,
  input  logic dn_ready,
  output s1_t  dn_s1
);

  logic valid_r;
  s1_t  s1_r;
  s1_t  s1_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_s1    = s1_r;

  // Constant-coefficient products and sums
  always_comb begin
    s1_nxt.side = up_pix.side;
    s1_nxt.rgb  = up_pix.rgb;
    s1_nxt.luma = LUMA_W'(LUMA_KR) * LUMA_W'(up_pix.rgb[0])
                + LUMA_W'(LUMA_KG) * LUMA_W'(up_pix.rgb[1])
                + LUMA_W'(LUMA_KB) * LUMA_W'(up_pix.rgb[2]);
    for (int i = 0; i < 3; i++) begin
      s1_nxt.sepia[i] = SEPIA_W'(SEPIA_K[i][0]) * SEPIA_W'(up_pix.rgb[0])
                      + SEPIA_W'(SEPIA_K[i][1]) * SEPIA_W'(up_pix.rgb[1])
                      + SEPIA_W'(SEPIA_K[i][2]) * SEPIA_W'(up_pix.rgb[2]);
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// File: hdl/pca_gain.sv
// Stages 2 and 3: difference term, then signed multiply by the factor.
module pca_gain import pca_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [MODE_W-1:0]          op_mode,
  input  logic signed [FACTOR_W-1:0] factor,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  s1_t                        up_s1,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output s3_t                        dn_s3
);

  logic s2_valid_r;
  logic s3_valid_r;
  logic s2_ready;
  logic s3_ready;
  s2_t  s2_r;
  s2_t  s2_nxt;
  s3_t  s3_r;
  s3_t  s3_nxt;

  assign s3_ready = !s3_valid_r || dn_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign up_ready = s2_ready;
  assign dn_valid = s3_valid_r;
  assign dn_s3    = s3_r;

  // Saturation takes c*2^16 - luma, contrast takes c - 128
  always_comb begin
    s2_nxt.side  = up_s1.side;
    s2_nxt.rgb   = up_s1.rgb;
    s2_nxt.luma  = up_s1.luma;
    s2_nxt.sepia = up_s1.sepia;
    for (int i = 0; i < 3; i++) begin
      if (op_mode == MODE_SAT) begin
        s2_nxt.diff[i] = DIFF_W'({up_s1.rgb[i], 16'h0000}) - DIFF_W'(up_s1.luma);
      end else begin
        s2_nxt.diff[i] = DIFF_W'(up_s1.rgb[i]) - DIFF_W'(CONTRAST_MID);
      end
    end
  end

  // Gain multiply, one 25x16 signed product per channel
  always_comb begin
    s3_nxt.side  = s2_r.side;
    s3_nxt.rgb   = s2_r.rgb;
    s3_nxt.luma  = s2_r.luma;
    s3_nxt.sepia = s2_r.sepia;
    for (int i = 0; i < 3; i++) begin
      s3_nxt.prod[i] = $signed(s2_r.diff[i]) * factor;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= up_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (up_valid && s2_ready) begin
      s2_r <= s2_nxt;
    end
    if (s2_valid_r && s3_ready) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// File: hdl/pca_clamp.sv
// Stage 4: operation select, floor, clamp and output register.
module pca_clamp import pca_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [MODE_W-1:0]          op_mode,
  input  logic signed [FACTOR_W-1:0] factor,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  s3_t                        up_s3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pix_t                       out_pix
);

  logic valid_r;
  pix_t pix_r;
  pix_t pix_nxt;

  logic signed [SUM_W-1:0] sum_b [3];
  logic signed [SUM_W-1:0] sum_c [3];
  logic signed [SUM_W-1:0] sum_s [3];
  logic signed [SUM_W-1:0] shr_c [3];
  logic signed [SUM_W-1:0] shr_s [3];
  logic [SEPIA_W-SEPIA_SHIFT-1:0] sep_q [3];

  assign up_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_pix   = pix_r;

  // Per-channel result
  always_comb begin
    pix_nxt.side = up_s3.side;
    for (int i = 0; i < 3; i++) begin
      sum_b[i] = $signed(SUM_W'(up_s3.rgb[i])) + SUM_W'(factor);
      sum_c[i] = $signed({up_s3.prod[i][PROD_W-1], up_s3.prod[i]})
               + $signed(SUM_W'(CONTRAST_BIAS));
      sum_s[i] = $signed({up_s3.prod[i][PROD_W-1], up_s3.prod[i]})
               + $signed(SUM_W'({up_s3.luma, 8'h00}));
      shr_c[i] = sum_c[i] >>> 8;
      shr_s[i] = sum_s[i] >>> 24;
      sep_q[i] = up_s3.sepia[i][SEPIA_W-1:SEPIA_SHIFT];
      case (op_mode)
        MODE_GRAY:     pix_nxt.rgb[i] = up_s3.luma[LUMA_W-1:LUMA_W-CH_W];
        MODE_SEPIA:    pix_nxt.rgb[i] = (sep_q[i] > (SEPIA_W-SEPIA_SHIFT)'(CH_MAX))
                                        ? CH_W'(CH_MAX) : sep_q[i][CH_W-1:0];
        MODE_INVERT:   pix_nxt.rgb[i] = ~up_s3.rgb[i];
        MODE_BRIGHT:   pix_nxt.rgb[i] = clamp8(sum_b[i]);
        MODE_CONTRAST: pix_nxt.rgb[i] = clamp8(shr_c[i]);
        MODE_SAT:      pix_nxt.rgb[i] = clamp8(shr_s[i]);
        default:       pix_nxt.rgb[i] = up_s3.rgb[i];
      endcase
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

// File: hdl/pixel_color_adjust.sv
// Top level of the pixel color adjust pipeline: config registers and stage wiring.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | in_red_in, in_green_in, in_blue_in,
//           |                      | in_alpha_in, in_last_in
//  out      | out_valid/out_ready  | out_red_out, out_green_out, out_blue_out,
//           |                      | out_alpha_out, out_last_out
//  cfg      | cfg_valid/cfg_ready  | cfg_index (2b), cfg_data (16b)
//
// Four register stages: sums, difference, multiply, select/clamp. One pixel
// per clock sustained while out_ready stays high.
// Every stage has its own valid and takes new data when empty or draining, so
// a stall on out backs up stage by stage and in_ready drops only when all four
// hold a pixel. cfg_ready is always high. Reset is synchronous and clears
// valids and the config registers (op_mode 0, adjust_factor 256).
module pixel_color_adjust import pca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CH_W-1:0]      in_red_in,
  input  logic [CH_W-1:0]      in_green_in,
  input  logic [CH_W-1:0]      in_blue_in,
  input  logic [CH_W-1:0]      in_alpha_in,
  input  logic                 in_last_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_red_out,
  output logic [CH_W-1:0]      out_green_out,
  output logic [CH_W-1:0]      out_blue_out,
  output logic [CH_W-1:0]      out_alpha_out,
  output logic                 out_last_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FACTOR_W-1:0]  cfg_data
);

  logic [MODE_W-1:0]          op_mode_r;
  logic signed [FACTOR_W-1:0] factor_r;

  pix_t in_pix;
  pix_t res_pix;
  s1_t  s1;
  s3_t  s3;
  logic s1_valid;
  logic s1_ready;
  logic s3_valid;
  logic s3_ready;

  // Config write decode
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_RESET;
      factor_r  <= FACTOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OP_MODE:       op_mode_r <= cfg_data[MODE_W-1:0];
        REG_ADJUST_FACTOR: factor_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pack input ports
  always_comb begin
    in_pix.side.alpha = in_alpha_in;
    in_pix.side.last  = in_last_in;
    in_pix.rgb[0]     = in_red_in;
    in_pix.rgb[1]     = in_green_in;
    in_pix.rgb[2]     = in_blue_in;
  end

  pca_luma u_luma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_pix   (in_pix),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_s1    (s1)
  );

  pca_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_mode  (op_mode_r),
    .factor   (factor_r),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_s1    (s1),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_s3    (s3)
  );

  pca_clamp u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_mode   (op_mode_r),
    .factor    (factor_r),
    .up_valid  (s3_valid),
    .up_ready  (s3_ready),
    .up_s3     (s3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (res_pix)
  );

  // Unpack result
  assign out_red_out   = res_pix.rgb[0];
  assign out_green_out = res_pix.rgb[1];
  assign out_blue_out  = res_pix.rgb[2];
  assign out_alpha_out = res_pix.side.alpha;
  assign out_last_out  = res_pix.side.last;

  // Input backs up only when every stage is full
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && s3_valid && out_valid && !out_ready))
    else $error("in_ready low with a free stage");

  // A held stage 3 output stays valid
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid && !s3_ready |=> s3_valid)
    else $error("stage 3 pixel dropped during stall");

  // Mode write lands in the register
  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_valid && (cfg_index == REG_OP_MODE)
    |=> op_mode_r == $past(cfg_data[MODE_W-1:0]))
    else $error("op_mode write lost");

  // Factor write lands in the register
  a_factor_write: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_valid && (cfg_index == REG_ADJUST_FACTOR)
    |=> factor_r == $signed($past(cfg_data)))
    else $error("adjust_factor write lost");

endmodule
